[src/nsr_pkg.sv]
package nsr_pkg;

  localparam int MAX_FRAME_BYTES    = 86;
  localparam int MIN_FRAME_BYTES    = 78;
  localparam int OPTION_FRAME_BYTES = 86;
  localparam int STORE_WORDS        = (MAX_FRAME_BYTES + 7) / 8;
  localparam int ADDR_W             = $clog2(STORE_WORDS);
  localparam int LEN_W              = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SUM_W              = 16 + $clog2(STORE_WORDS * 4 + 2);
  localparam int CFG_IDX_W          = 3;

  localparam int OFF_MAC  = 6;
  localparam int OFF_ETH  = 12;
  localparam int OFF_PLEN = 18;
  localparam int OFF_NH   = 20;
  localparam int OFF_SRC  = 22;
  localparam int OFF_TYPE = 54;
  localparam int OFF_CSUM = 56;
  localparam int OFF_TGT  = 62;
  localparam int OFF_MAC2 = 80;

  localparam logic [15:0] ETH_IPV6  = 16'h86DD;
  localparam logic [7:0]  NH_ICMPV6 = 8'h3A;
  localparam logic [7:0]  ICMP_NS   = 8'h87;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_LOCAL_UPPER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_LOCAL_LOWER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_FIRST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_SECOND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIXES_IN_USE  = 3'd5;

  localparam logic [2:0] VERDICT_PASS       = 3'd0;
  localparam logic [2:0] VERDICT_SHORT      = 3'd1;
  localparam logic [2:0] VERDICT_NOT_IPV6   = 3'd2;
  localparam logic [2:0] VERDICT_NOT_ICMPV6 = 3'd3;
  localparam logic [2:0] VERDICT_NOT_NS     = 3'd4;
  localparam logic [2:0] VERDICT_PREFIX     = 3'd5;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [3:0]  word_bytes;
    logic        frame_end;
  } frame_in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        out_last;
    logic [2:0]  verdict;
  } result_t;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [63:0] link_local_upper;
    logic [63:0] link_local_lower;
    logic [63:0] prefix_first;
    logic [63:0] prefix_second;
    logic [1:0]  prefixes_in_use;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] csum;
  } status_t;

  // substitutes mac, ipv6 source and checksum bytes; zeroes bytes past the frame end
  function automatic logic [63:0] nsr_rewrite(input logic [63:0]      word,
                                              input logic [ADDR_W-1:0] idx,
                                              input logic [LEN_W-1:0]  len,
                                              input cfg_t              cfg,
                                              input logic [15:0]       csum);
    logic [63:0]  res;
    logic [7:0]   b;
    logic [47:0]  mac_sh;
    logic [127:0] src_sh;
    int           p;
    int           n;
    res = '0;
    n   = int'(len);
    for (int j = 0; j < 8; j++) begin
      p = int'(idx) * 8 + j;
      b = word[63 - 8 * j -: 8];
      if (p >= n) begin
        b = 8'h00;
      end else if (p >= OFF_MAC && p < OFF_MAC + 6) begin
        mac_sh = cfg.source_mac << (8 * (p - OFF_MAC));
        b      = mac_sh[47:40];
      end else if (p >= OFF_MAC2 && p < OFF_MAC2 + 6 && n == OPTION_FRAME_BYTES) begin
        mac_sh = cfg.source_mac << (8 * (p - OFF_MAC2));
        b      = mac_sh[47:40];
      end else if (p >= OFF_SRC && p < OFF_SRC + 16) begin
        src_sh = {cfg.link_local_upper, cfg.link_local_lower} << (8 * (p - OFF_SRC));
        b      = src_sh[127:120];
      end else if (p == OFF_CSUM) begin
        b = csum[15:8];
      end else if (p == OFF_CSUM + 1) begin
        b = csum[7:0];
      end
      res[63 - 8 * j -: 8] = b;
    end
    return res;
  endfunction

endpackage

[src/nsr_frame_mem.sv]
module nsr_frame_mem import nsr_pkg::*; (
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [63:0]       rd_data
);

  logic [63:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/nsr_packer.sv]
module nsr_packer import nsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  frame_in_t        item,
  input  logic             flush,
  output logic [LEN_W-1:0] byte_total,
  output mem_wr_t          wr
);

  logic [63:0]      acc;
  logic [63:0]      acc_next;
  logic [LEN_W-1:0] byte_total_next;
  logic [2:0]       acc_n;
  logic [3:0]       n;
  logic [3:0]       take;
  logic [3:0]       total;
  logic [63:0]      keep;
  logic [127:0]     merged;
  int               room;

  assign acc_n = byte_total[2:0];

  always_comb begin
    n      = (item.word_bytes > 4'd8) ? 4'd8 : item.word_bytes;
    room   = MAX_FRAME_BYTES - int'(byte_total);
    take   = (int'(n) > room) ? 4'(room) : n;
    keep   = ~({64{1'b1}} >> {take, 3'b000});
    merged = {acc, 64'h0} | ({item.frame_word & keep, 64'h0} >> {acc_n, 3'b000});
    total  = {1'b0, acc_n} + take;

    wr              = '0;
    acc_next        = acc;
    byte_total_next = byte_total;
    if (accept) begin
      byte_total_next = byte_total + LEN_W'(take);
      if (total >= 4'd8) begin
        wr.en    = 1'b1;
        wr.addr  = ADDR_W'(byte_total >> 3);
        wr.data  = merged[127:64];
        acc_next = merged[63:0];
      end else begin
        acc_next = merged[127:64];
      end
    end else if (flush) begin
      // partial tail word
      wr.en           = (acc_n != 3'd0);
      wr.addr         = ADDR_W'(byte_total >> 3);
      wr.data         = acc;
      acc_next        = '0;
      byte_total_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      byte_total <= '0;
    end else begin
      acc        <= acc_next;
      byte_total <= byte_total_next;
    end
  end

endmodule

[src/nsr_checker.sv]
module nsr_checker import nsr_pkg::*; (
  input  logic              clk,
  input  logic              clear,
  input  logic              word_valid,
  input  logic [ADDR_W-1:0] word_idx,
  input  logic [63:0]       word,
  input  logic [LEN_W-1:0]  len,
  input  cfg_t              cfg,
  output status_t           status
);

  localparam int TGT_SPLIT = 8 - (OFF_TGT % 8);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [15:0]      eth_type;
  logic [7:0]       next_hdr;
  logic [7:0]       icmp_type;
  logic [63:0]      target;
  logic [63:0]      rw;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  logic             hit;
  int               p;

  always_comb begin
    rw       = nsr_rewrite(word, word_idx, len, cfg, 16'h0000);
    sum_next = sum;
    for (int j = 0; j < 4; j++) begin
      p = int'(word_idx) * 8 + 2 * j;
      if (p >= OFF_SRC || p == OFF_PLEN) begin
        sum_next = sum_next + SUM_W'(rw[63 - 16 * j -: 16]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= SUM_W'(NH_ICMPV6);
    end else if (word_valid) begin
      sum <= sum_next;
      if (word_idx == ADDR_W'(OFF_ETH / 8)) begin
        eth_type <= word[63 - 8 * (OFF_ETH % 8) -: 16];
      end
      if (word_idx == ADDR_W'(OFF_NH / 8)) begin
        next_hdr <= word[63 - 8 * (OFF_NH % 8) -: 8];
      end
      if (word_idx == ADDR_W'(OFF_TYPE / 8)) begin
        icmp_type <= word[63 - 8 * (OFF_TYPE % 8) -: 8];
      end
      if (word_idx == ADDR_W'(OFF_TGT / 8)) begin
        target[63 -: 8 * TGT_SPLIT] <= word[8 * TGT_SPLIT - 1:0];
      end
      if (word_idx == ADDR_W'(OFF_TGT / 8 + 1)) begin
        target[63 - 8 * TGT_SPLIT:0] <= word[63 -: 64 - 8 * TGT_SPLIT];
      end
    end
  end

  always_comb begin
    hit = (cfg.prefixes_in_use != 2'd0 && target == cfg.prefix_first) ||
          (cfg.prefixes_in_use[1] && target == cfg.prefix_second);
    if (int'(len) < MIN_FRAME_BYTES) begin
      status.verdict = VERDICT_SHORT;
    end else if (eth_type != ETH_IPV6) begin
      status.verdict = VERDICT_NOT_IPV6;
    end else if (next_hdr != NH_ICMPV6) begin
      status.verdict = VERDICT_NOT_ICMPV6;
    end else if (icmp_type != ICMP_NS) begin
      status.verdict = VERDICT_NOT_NS;
    end else if (!hit) begin
      status.verdict = VERDICT_PREFIX;
    end else begin
      status.verdict = VERDICT_PASS;
    end
    fold1       = 17'(sum[15:0]) + 17'(sum[SUM_W-1:16]);
    fold2       = fold1[15:0] + 16'(fold1[16]);
    status.csum = ~fold2;
  end

endmodule

[src/neighbor_solicitation_rewriter.sv]
// sequence: after the last input beat the block passes through flush, scan and scan-last,
//   decide, then an emit read and load per beat (drop: load only; short frames skip scan)
// throughput: 1 input beat per cycle while filling; each forwarded beat takes one memory read
//   and one output load, and a load waits while the output is stalled; input stalls from the
//   last beat of a frame until its last result beat is loaded
// reset: synchronous rst clears control and loads register defaults; frame memory is not cleared
module neighbor_solicitation_rewriter import nsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 frame_valid,
  output logic                 frame_stall,
  input  frame_in_t            frame_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam logic [2:0] ST_FILL      = 3'd0;
  localparam logic [2:0] ST_FLUSH     = 3'd1;
  localparam logic [2:0] ST_SCAN      = 3'd2;
  localparam logic [2:0] ST_SCAN_LAST = 3'd3;
  localparam logic [2:0] ST_DECIDE    = 3'd4;
  localparam logic [2:0] ST_DROP      = 3'd5;
  localparam logic [2:0] ST_EMIT_RD   = 3'd6;
  localparam logic [2:0] ST_EMIT_LD   = 3'd7;

  logic [2:0]        state;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] scan_idx;
  logic [LEN_W-1:0]  len;
  logic [LEN_W:0]    len_up;
  logic [ADDR_W-1:0] last_idx;
  logic              scan_valid;
  cfg_t              cfg;
  status_t           status;
  mem_wr_t           mem_wr;
  logic [LEN_W-1:0]  frame_len;
  logic [63:0]       rd_data;
  logic              rd_en;
  logic              frame_accept;
  logic              flush;
  logic              out_free;
  logic [3:0]        emit_bytes;
  int                rem;

  assign frame_stall  = (state != ST_FILL);
  assign frame_accept = frame_valid && !frame_stall;
  assign flush        = (state == ST_FLUSH);
  assign rd_en        = (state == ST_SCAN) || (state == ST_EMIT_RD);
  assign out_free     = !result_valid || !result_stall;
  assign len_up       = {1'b0, len} + (LEN_W + 1)'(7);
  assign last_idx     = ADDR_W'((len_up >> 3) - 1'b1);

  always_comb begin
    rem        = int'(len) - int'(idx) * 8;
    emit_bytes = (rem >= 8) ? 4'd8 : 4'(rem);
  end

  nsr_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .accept     (frame_accept),
    .item       (frame_data),
    .flush      (flush),
    .byte_total (frame_len),
    .wr         (mem_wr)
  );

  nsr_frame_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  nsr_checker u_checker (
    .clk        (clk),
    .clear      (flush),
    .word_valid (scan_valid),
    .word_idx   (scan_idx),
    .word       (rd_data),
    .len        (len),
    .cfg        (cfg),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      idx          <= '0;
      len          <= '0;
      scan_valid   <= 1'b0;
      result_valid <= 1'b0;
      cfg          <= {{($bits(cfg_t) - 2){1'b0}}, 2'd1};
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE_MAC:       cfg.source_mac       <= cfg_data[47:0];
          REG_LINK_LOCAL_UPPER: cfg.link_local_upper <= cfg_data;
          REG_LINK_LOCAL_LOWER: cfg.link_local_lower <= cfg_data;
          REG_PREFIX_FIRST:     cfg.prefix_first     <= cfg_data;
          REG_PREFIX_SECOND:    cfg.prefix_second    <= cfg_data;
          REG_PREFIXES_IN_USE:  cfg.prefixes_in_use  <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
      scan_valid <= (state == ST_SCAN);
      if ((state == ST_DROP || state == ST_EMIT_LD) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_FILL: begin
          if (frame_accept && frame_data.frame_end) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          len   <= frame_len;
          idx   <= '0;
          state <= (int'(frame_len) < MIN_FRAME_BYTES) ? ST_DECIDE : ST_SCAN;
        end
        ST_SCAN: begin
          idx <= idx + 1'b1;
          if (idx == last_idx) begin
            state <= ST_SCAN_LAST;
          end
        end
        ST_SCAN_LAST: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          idx   <= '0;
          state <= (status.verdict == VERDICT_PASS) ? ST_EMIT_RD : ST_DROP;
        end
        ST_DROP: begin
          if (out_free) begin
            state <= ST_FILL;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (out_free) begin
            idx   <= idx + 1'b1;
            state <= (idx == last_idx) ? ST_FILL : ST_EMIT_RD;
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      scan_idx <= idx;
    end
    if (state == ST_DROP && out_free) begin
      result_data.out_word  <= '0;
      result_data.out_bytes <= 4'd0;
      result_data.out_last  <= 1'b1;
      result_data.verdict   <= status.verdict;
    end else if (state == ST_EMIT_LD && out_free) begin
      result_data.out_word  <= nsr_rewrite(rd_data, idx, len, cfg, status.csum);
      result_data.out_bytes <= emit_bytes;
      result_data.out_last  <= (idx == last_idx);
      result_data.verdict   <= VERDICT_PASS;
    end
  end

  a_drop_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.verdict != VERDICT_PASS
      |-> result_data.out_bytes == 4'd0 && result_data.out_last)
    else $error("drop beat carries data or is not last");

  a_pass_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.verdict == VERDICT_PASS |-> result_data.out_bytes != 4'd0)
    else $error("forwarded beat without bytes");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> state == ST_FILL || state == ST_FLUSH)
    else $error("frame memory written outside fill");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_LD || state == ST_EMIT_RD |-> idx <= last_idx)
    else $error("emit index past frame end");

  a_scan_to_decide: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN_LAST |=> state == ST_DECIDE && !scan_valid)
    else $error("scan did not finish before decide");

endmodule

[dv/neighbor_solicitation_rewriter_test.sv]
`timescale 1ns / 1ps

module neighbor_solicitation_rewriter_test;
  import nsr_pkg::*;

  localparam int STORE_BYTES   = STORE_WORDS * 8;
  localparam int ITEM_TARGET   = 310;
  localparam int SETTLE_CYCLES = 2 * STORE_WORDS + 8;
  localparam int HOLD_OFF      = 300;
  localparam int LIMIT_NS      = 400_000;

  typedef logic [7:0] octet_q_t [$];

  typedef enum int {
    FLAW_NONE,
    FLAW_ETHERTYPE,
    FLAW_NEXT_HEADER,
    FLAW_ICMP_TYPE,
    FLAW_PREFIX,
    FLAW_NOISE
  } flaw_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 frame_valid  = 1'b0;
  logic                 frame_stall;
  frame_in_t            frame_data   = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result_data;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [63:0]          cfg_data     = '0;

  // predictor copy of the registers and the frame buffer
  logic [47:0] mac_cfg   = '0;
  logic [63:0] ll_upper  = '0;
  logic [63:0] ll_lower  = '0;
  logic [63:0] pfx_a     = '0;
  logic [63:0] pfx_b     = '0;
  logic [1:0]  pfx_count = 2'd1;
  logic [7:0]  kept [0:STORE_BYTES-1] = '{default: 8'h00};
  int          kept_len = 0;

  result_t expected_beats [$];
  int      failures      = 0;
  int      beats_sent    = 0;
  int      hold_cycles   = 0;
  bit      sender_steady = 1'b0;
  bit      sink_steady   = 1'b0;

  neighbor_solicitation_rewriter dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_data   (frame_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic report(input string msg);
    $display("[%0t] %s", $time, msg);
    failures++;
  endtask

  task automatic predict_rewrite(input frame_in_t beat);
    int          n;
    int          k;
    int          i;
    int          len;
    logic [2:0]  verdict;
    logic [63:0] tgt;
    logic [31:0] sum;
    logic [15:0] csum;
    logic [7:0]  lo;
    result_t     r;
    n = (beat.word_bytes > 4'd8) ? 8 : int'(beat.word_bytes);
    for (k = 0; k < n; k++) begin
      if (kept_len < MAX_FRAME_BYTES) begin
        kept[kept_len] = beat.frame_word[63 - 8 * k -: 8];
        kept_len++;
      end
    end
    if (!beat.frame_end) return;
    len = kept_len;
    kept_len = 0;
    tgt = '0;
    for (k = 0; k < 8; k++) tgt = {tgt[55:0], kept[OFF_TGT + k]};
    if (len < MIN_FRAME_BYTES) verdict = VERDICT_SHORT;
    else if ({kept[OFF_ETH], kept[OFF_ETH + 1]} != ETH_IPV6) verdict = VERDICT_NOT_IPV6;
    else if (kept[OFF_NH] != NH_ICMPV6) verdict = VERDICT_NOT_ICMPV6;
    else if (kept[OFF_TYPE] != ICMP_NS) verdict = VERDICT_NOT_NS;
    else if ((pfx_count >= 2'd1 && tgt == pfx_a) || (pfx_count >= 2'd2 && tgt == pfx_b))
      verdict = VERDICT_PASS;
    else verdict = VERDICT_PREFIX;
    if (verdict != VERDICT_PASS) begin
      r = '0;
      r.out_last = 1'b1;
      r.verdict = verdict;
      expected_beats = {expected_beats, r};
      return;
    end
    for (k = 0; k < 6; k++) begin
      kept[OFF_MAC + k] = mac_cfg[47 - 8 * k -: 8];
      if (len == OPTION_FRAME_BYTES) kept[OFF_MAC2 + k] = mac_cfg[47 - 8 * k -: 8];
    end
    for (k = 0; k < 8; k++) begin
      kept[OFF_SRC + k]     = ll_upper[63 - 8 * k -: 8];
      kept[OFF_SRC + 8 + k] = ll_lower[63 - 8 * k -: 8];
    end
    kept[OFF_CSUM]     = 8'h00;
    kept[OFF_CSUM + 1] = 8'h00;
    sum = 32'h3A + {kept[OFF_PLEN], kept[OFF_PLEN + 1]};
    for (i = OFF_SRC; i < len; i += 2) begin
      lo = (i + 1 < len) ? kept[i + 1] : 8'h00;
      sum += {kept[i], lo};
    end
    while (sum >> 16) sum = (sum >> 16) + (sum & 32'hFFFF);
    csum = ~sum[15:0];
    kept[OFF_CSUM]     = csum[15:8];
    kept[OFF_CSUM + 1] = csum[7:0];
    for (k = 0; k < len; k += 8) begin
      r = '0;
      for (i = 0; i < 8; i++)
        if (k + i < len) r.out_word[63 - 8 * i -: 8] = kept[k + i];
      r.out_bytes = (len - k < 8) ? 4'(len - k) : 4'd8;
      r.out_last  = (k + 8 >= len);
      r.verdict   = VERDICT_PASS;
      expected_beats = {expected_beats, r};
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_beats.size() == 0) begin
      report($sformatf("result beat with nothing pending: %h", got));
      return;
    end
    want = expected_beats.pop_front();
    if (got.out_word !== want.out_word)
      report($sformatf("out_word got %h want %h", got.out_word, want.out_word));
    if (got.out_bytes !== want.out_bytes)
      report($sformatf("out_bytes got %0d want %0d", got.out_bytes, want.out_bytes));
    if (got.out_last !== want.out_last)
      report($sformatf("out_last got %b want %b", got.out_last, want.out_last));
    if (got.verdict !== want.verdict)
      report($sformatf("verdict got %0d want %0d", got.verdict, want.verdict));
  endtask

  // result side: random stall after each beat unless the sink is steady, long hold-off on request
  initial begin : result_sink
    int  n;
    bit  took;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      took = result_valid && !result_stall;
      if (took) check_result(result_data);
      n = 0;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else if (took && !sink_steady) begin
        n = $urandom_range(0, 17);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(input frame_in_t beat);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_data  <= beat;
    frame_valid <= 1'b1;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    predict_rewrite(beat);
    beats_sent++;
  endtask

  task automatic send_frame(input octet_q_t fb, input bit ragged, input bit empty_tail);
    int        pos;
    int        take;
    int        field;
    int        k;
    frame_in_t beat;
    pos = 0;
    do begin
      field = ragged ? $urandom_range(0, 15) : 8;
      take  = (field > 8) ? 8 : field;
      if (take >= fb.size() - pos) begin
        take = fb.size() - pos;
        if (field <= 8 || take < 8) field = take;
      end
      beat.frame_word = {$urandom, $urandom};
      for (k = 0; k < take; k++) beat.frame_word[63 - 8 * k -: 8] = fb[pos + k];
      beat.word_bytes = 4'(field);
      pos += take;
      beat.frame_end = (pos >= fb.size()) && !empty_tail;
      send_beat(beat);
    end while (pos < fb.size());
    if (empty_tail) begin
      beat.frame_word = {$urandom, $urandom};
      beat.word_bytes = 4'd0;
      beat.frame_end  = 1'b1;
      send_beat(beat);
    end
  endtask

  task automatic build_frame(input int len, input flaw_t flaw, output octet_q_t fb);
    int          i;
    logic [63:0] tgt;
    logic [15:0] eth;
    logic [7:0]  nh;
    logic [7:0]  icmp;
    logic [7:0]  b;
    tgt  = ($urandom_range(0, 1) == 0) ? pfx_a : pfx_b;
    eth  = ETH_IPV6;
    nh   = NH_ICMPV6;
    icmp = ICMP_NS;
    case (flaw)
      FLAW_ETHERTYPE:   eth  = eth ^ (16'h1 << $urandom_range(0, 15));
      FLAW_NEXT_HEADER: nh   = nh ^ (8'h1 << $urandom_range(0, 7));
      FLAW_ICMP_TYPE:   icmp = icmp ^ (8'h1 << $urandom_range(0, 7));
      FLAW_PREFIX:      tgt  = tgt ^ (64'h1 << $urandom_range(0, 63));
      default: ;
    endcase
    fb = {};
    for (i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (flaw != FLAW_NOISE) begin
        if (i == OFF_ETH) b = eth[15:8];
        else if (i == OFF_ETH + 1) b = eth[7:0];
        else if (i == OFF_NH) b = nh;
        else if (i == OFF_TYPE) b = icmp;
        else if (i >= OFF_TGT && i < OFF_TGT + 8) b = tgt[63 - 8 * (i - OFF_TGT) -: 8];
      end
      fb = {fb, b};
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SOURCE_MAC:       mac_cfg   = data[47:0];
      REG_LINK_LOCAL_UPPER: ll_upper  = data;
      REG_LINK_LOCAL_LOWER: ll_lower  = data;
      REG_PREFIX_FIRST:     pfx_a     = data;
      REG_PREFIX_SECOND:    pfx_b     = data;
      REG_PREFIXES_IN_USE:  pfx_count = data[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [63:0] mac, input logic [63:0] upper,
                                input logic [63:0] lower, input logic [63:0] first,
                                input logic [63:0] second, input logic [1:0] count);
    write_reg(REG_SOURCE_MAC, mac);
    write_reg(REG_LINK_LOCAL_UPPER, upper);
    write_reg(REG_LINK_LOCAL_LOWER, lower);
    write_reg(REG_PREFIX_FIRST, first);
    write_reg(REG_PREFIX_SECOND, second);
    write_reg(REG_PREFIXES_IN_USE, {$urandom, 30'($urandom), count});
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    frame_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_frame();
    int       r;
    int       len;
    flaw_t    flaw;
    octet_q_t fb;
    r = $urandom_range(0, 99);
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(MIN_FRAME_BYTES, MAX_FRAME_BYTES)
                                       : $urandom_range(MAX_FRAME_BYTES + 1, 130);
    flaw = FLAW_NONE;
    if (r >= 92) begin
      flaw = FLAW_NOISE;
      len  = $urandom_range(0, 130);
    end else if (r >= 86) len = $urandom_range(0, MIN_FRAME_BYTES - 1);
    else if (r >= 80) flaw = FLAW_PREFIX;
    else if (r >= 75) flaw = FLAW_ICMP_TYPE;
    else if (r >= 70) flaw = FLAW_NEXT_HEADER;
    else if (r >= 65) flaw = FLAW_ETHERTYPE;
    build_frame(len, flaw, fb);
    sender_steady = ($urandom_range(0, 4) == 0);
    sink_steady   = ($urandom_range(0, 4) == 0);
    send_frame(fb, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
  endtask

  // reset registers: prefix zero with one prefix compared, full option length
  task automatic test_reset_defaults();
    octet_q_t fb;
    build_frame(OPTION_FRAME_BYTES, FLAW_NONE, fb);
    send_frame(fb, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_edge_frames();
    octet_q_t  fb;
    frame_in_t beat;
    apply_settings('1, '1, '1, '1, '0, 2'd2);
    fb = {};
    send_frame(fb, 1'b0, 1'b0);
    beat.frame_word = '1;
    beat.word_bytes = 4'd15;
    beat.frame_end  = 1'b1;
    send_beat(beat);
    build_frame(MIN_FRAME_BYTES, FLAW_NONE, fb);
    send_frame(fb, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    octet_q_t fb;
    int       i;
    apply_settings(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(), 2'd2);
    hold_cycles   = HOLD_OFF;
    sender_steady = 1'b1;
    for (i = 0; i < 4; i++) begin
      build_frame(OPTION_FRAME_BYTES, FLAW_NONE, fb);
      send_frame(fb, 1'b0, 1'b0);
    end
    sender_steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int         phase;
    int         i;
    logic [1:0] count;
    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      case (phase)
        0: apply_settings('1, '1, '1, '1, '1, 2'd3);
        1: apply_settings('0, '0, '0, '0, '0, 2'd0);
        default: begin
          count = (phase == 2) ? 2'd2 : (phase == 3) ? 2'd1 : 2'($urandom_range(0, 3));
          apply_settings(pick_value(), pick_value(), pick_value(), pick_value(),
                         pick_value(), count);
        end
      endcase
      for (i = 0; i < 6; i++) send_random_frame();
      sender_steady = 1'b0;
      sink_steady   = 1'b0;
      wait_idle();
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_edge_frames();
    test_backpressure();
    test_random_traffic();
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("Test completed with failures");
    $finish;
  end

endmodule
